### hw/rtl/irpwc_pkg.sv
// ---------------------------------------------------------------------------
// IR pulse width capture package
// Shared types and register indexes for the capture block.
// ---------------------------------------------------------------------------
package irpwc_pkg;

    localparam int TicksW   = 16;
    localparam int IndexW   = 7;
    localparam int CountW   = 8;
    localparam int CfgAddrW = 1;
    localparam int CfgDataW = 16;

    localparam logic [TicksW-1:0] TimerMax     = '1;
    localparam logic [TicksW-1:0] GapThreshRst = 16'd100;

    localparam logic [CfgAddrW-1:0] RegGapThreshold   = 1'd0;
    localparam logic [CfgAddrW-1:0] RegIndicatorEnable = 1'd1;

    localparam logic CmdTick   = 1'b0;
    localparam logic CmdResume = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MARK  = 4'b0010,
        ST_SPACE = 4'b0100,
        ST_STOP  = 4'b1000
    } cap_state_t;

    typedef struct packed {
        logic              valid;
        logic [IndexW-1:0] index;
        logic [TicksW-1:0] ticks;
    } rec_t;

endpackage

### hw/rtl/irpwc_step.sv
// ---------------------------------------------------------------------------
// IR pulse width capture step
// Next-state and record logic for one sample tick or resume command.
// ---------------------------------------------------------------------------
module irpwc_step #(
    parameter int CntW = 8,
    parameter int BufEntries = 128
) (
    input  logic                      command,
    input  logic                      line_is_mark,
    input  logic [irpwc_pkg::TicksW-1:0] gap_threshold,
    input  logic                      indicator_enable,
    input  irpwc_pkg::cap_state_t     state,
    input  logic [irpwc_pkg::TicksW-1:0] timer,
    input  logic [CntW-1:0]           cnt,
    input  logic                      ind,
    output irpwc_pkg::cap_state_t     state_next,
    output logic [irpwc_pkg::TicksW-1:0] timer_next,
    output logic [CntW-1:0]           cnt_next,
    output logic                      ind_next,
    output irpwc_pkg::rec_t           rec
);
    import irpwc_pkg::*;

    localparam int WideW = (CntW > IndexW) ? CntW : IndexW;

    logic [TicksW-1:0] timer_inc;
    cap_state_t        state_eff;
    logic [WideW-1:0]  cnt_wide;
    logic [IndexW-1:0] cur_index;

    assign timer_inc = (timer == TimerMax) ? timer : timer + 1'b1;
    assign state_eff = (cnt >= CntW'(BufEntries)) ? ST_STOP : state;
    assign cnt_wide  = WideW'(cnt);
    assign cur_index = cnt_wide[IndexW-1:0];

    always_comb
    begin
        state_next = state;
        timer_next = timer;
        cnt_next   = cnt;
        ind_next   = ind;
        rec        = '0;
        if (command == CmdResume)
        begin
            state_next = ST_IDLE;
            cnt_next   = '0;
        end
        else
        begin
            state_next = state_eff;
            timer_next = timer_inc;
            unique case (state_eff)
                ST_IDLE:
                begin
                    if (line_is_mark)
                    begin
                        timer_next = '0;
                        if (timer_inc >= gap_threshold)
                        begin
                            rec.valid  = 1'b1;
                            rec.ticks  = timer_inc;
                            cnt_next   = CntW'(1);
                            state_next = ST_MARK;
                        end
                    end
                end
                ST_MARK:
                begin
                    if (!line_is_mark)
                    begin
                        rec.valid  = 1'b1;
                        rec.index  = cur_index;
                        rec.ticks  = timer_inc;
                        cnt_next   = cnt + 1'b1;
                        timer_next = '0;
                        state_next = ST_SPACE;
                    end
                end
                ST_SPACE:
                begin
                    if (line_is_mark)
                    begin
                        rec.valid  = 1'b1;
                        rec.index  = cur_index;
                        rec.ticks  = timer_inc;
                        cnt_next   = cnt + 1'b1;
                        timer_next = '0;
                        state_next = ST_MARK;
                    end
                    else if (timer_inc > gap_threshold)
                    begin
                        state_next = ST_STOP;
                    end
                end
                ST_STOP:
                begin
                    if (line_is_mark)
                    begin
                        timer_next = '0;
                    end
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
            if (indicator_enable)
            begin
                ind_next = line_is_mark;
            end
        end
    end

endmodule

### hw/rtl/ir_pulse_width_capture.sv
// ---------------------------------------------------------------------------
// IR pulse width capture
// Measures gap, mark and space durations of a demodulated infrared line.
// ---------------------------------------------------------------------------
// Input beats arrive on s_tvalid/s_tready: s_tuser is the command (0 = sample
// tick, 1 = resume capture), s_tdata[0] the sampled line level. Every input
// beat yields exactly one output beat on m_tvalid/m_tready: m_tuser is
// record_valid, m_tdata carries index, ticks, frame_done, entry_count and
// the indicator level.
// The state update and the result are computed in a single pass from the
// state registers and the input beat, and the result lands in the output
// register on the accepting edge. One beat is taken per cycle while the
// receiver does not stall; the output register is the only stage.
// When the receiver stalls, s_tready drops while a result is held and rises
// again in the cycle the result is taken, so no bubble is inserted.
// Configuration writes (cfg_we, cfg_addr, cfg_wdata) take effect on the
// next edge: index 0 is the gap threshold, index 1 the indicator enable.
// Reset puts capture in idle with timer, entry count and indicator cleared,
// the gap threshold at 100 and the indicator disabled; no beat is pending.
// ---------------------------------------------------------------------------
module ir_pulse_width_capture #(
    parameter int BUFFER_ENTRIES = 128
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [irpwc_pkg::CfgAddrW-1:0]  cfg_addr,
    input  logic [irpwc_pkg::CfgDataW-1:0]  cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,  // [0] line_is_mark, [7:1] zero
    input  logic                            s_tuser,  // [0] command
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [39:0]                     m_tdata,  // [6:0] record_index,
                                                      // [22:7] record_ticks,
                                                      // [23] frame_done,
                                                      // [31:24] entry_count,
                                                      // [32] indicator, [39:33] zero
    output logic                            m_tuser   // [0] record_valid
);
    import irpwc_pkg::*;

    localparam int CntW  = $clog2(BUFFER_ENTRIES + 1);
    localparam int WideW = (CntW > CountW) ? CntW : CountW;

    logic [TicksW-1:0] gap_threshold_reg;
    logic              indicator_enable_reg;
    cap_state_t        state_reg;
    cap_state_t        state_next;
    logic [TicksW-1:0] timer_reg;
    logic [TicksW-1:0] timer_next;
    logic [CntW-1:0]   cnt_reg;
    logic [CntW-1:0]   cnt_next;
    logic              ind_reg;
    logic              ind_next;
    rec_t              rec;
    logic              accept;
    logic              out_valid_reg;
    logic [39:0]       out_data_reg;
    logic [39:0]       out_data_next;
    logic              out_user_reg;
    logic [WideW-1:0]  cnt_wide;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    irpwc_step #(
        .CntW       (CntW),
        .BufEntries (BUFFER_ENTRIES)
    ) u_step (
        .command          (s_tuser),
        .line_is_mark     (s_tdata[0]),
        .gap_threshold    (gap_threshold_reg),
        .indicator_enable (indicator_enable_reg),
        .state            (state_reg),
        .timer            (timer_reg),
        .cnt              (cnt_reg),
        .ind              (ind_reg),
        .state_next       (state_next),
        .timer_next       (timer_next),
        .cnt_next         (cnt_next),
        .ind_next         (ind_next),
        .rec              (rec)
    );

    assign cnt_wide = WideW'(cnt_next);

    always_comb
    begin
        out_data_next        = '0;
        out_data_next[6:0]   = rec.index;
        out_data_next[22:7]  = rec.ticks;
        out_data_next[23]    = (state_next == ST_STOP);
        out_data_next[31:24] = cnt_wide[CountW-1:0];
        out_data_next[32]    = ind_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_threshold_reg    <= GapThreshRst;
            indicator_enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                RegGapThreshold:    gap_threshold_reg    <= cfg_wdata;
                RegIndicatorEnable: indicator_enable_reg <= cfg_wdata[0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            timer_reg     <= '0;
            cnt_reg       <= '0;
            ind_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= state_next;
                timer_reg <= timer_next;
                cnt_reg   <= cnt_next;
                ind_reg   <= ind_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= rec.valid;
        end
    end

`ifndef SYNTHESIS
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while a result is stalled");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CntW'(BUFFER_ENTRIES))
        else $error("entry count beyond buffer size");

    a_record_not_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> !m_tdata[23])
        else $error("record issued together with stopped state");

    a_resume_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tuser) |=> (state_reg == ST_IDLE && cnt_reg == '0))
        else $error("resume did not rearm capture");
`endif

endmodule
